### rtl/cordic_sine_cosine_macros.svh
// Assertion helpers shared by the CORDIC pipeline files.
`ifndef CORDIC_SINE_COSINE_MACROS_SVH
`define CORDIC_SINE_COSINE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CSC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("CORDIC check failed");

// Implication whose consequent is checked in the next cycle.
`define CSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("CORDIC check failed");

`endif

### rtl/csc_pkg.sv
package csc_pkg;

   localparam int ANGLE_WIDTH       = 17;
   localparam int OUT_WIDTH         = 18;
   // Vector magnitude stays below about 1.65 * 39797, so 20 bits leave headroom.
   localparam int XY_WIDTH          = 20;
   // Input angle plus the whole arctangent sum stays well inside 19 bits.
   localparam int Z_WIDTH           = 19;
   localparam int COUNT_WIDTH       = 5;
   localparam int TABLE_LEN         = 16;
   localparam int DEFAULT_MAX_STEPS = 16;
   localparam int COUNT_RESET       = 16;
   localparam int GAIN_Q16          = 39797;
   localparam int OUT_LIMIT         = 65536;

   typedef logic signed [XY_WIDTH-1:0] xy_type;
   typedef logic signed [Z_WIDTH-1:0]  z_type;

   typedef struct packed {
      xy_type x;
      xy_type y;
      z_type  z;
   } rot_type;

   // Arctangent of 2^-idx in radians, scaled by 2^15.
   function automatic z_type arctan_q15(input int idx);
      z_type value;
      unique case (idx)
         0:       value = Z_WIDTH'(25735);
         1:       value = Z_WIDTH'(15192);
         2:       value = Z_WIDTH'(8027);
         3:       value = Z_WIDTH'(4074);
         4:       value = Z_WIDTH'(2045);
         5:       value = Z_WIDTH'(1024);
         6:       value = Z_WIDTH'(512);
         7:       value = Z_WIDTH'(256);
         8:       value = Z_WIDTH'(128);
         9:       value = Z_WIDTH'(64);
         10:      value = Z_WIDTH'(32);
         11:      value = Z_WIDTH'(16);
         12:      value = Z_WIDTH'(8);
         13:      value = Z_WIDTH'(4);
         14:      value = Z_WIDTH'(2);
         15:      value = Z_WIDTH'(1);
         default: value = '0;
      endcase
      return value;
   endfunction

endpackage

### rtl/cordic_sine_cosine.sv
// Channel   Direction  Handshake              Payload
// request   in         req_valid / req_ready  req_angle (17b signed, rad * 2^15)
// response  out        rsp_valid / rsp_ready  rsp_cosine, rsp_sine (18b signed, Q16)
// csr       in         csr_write_enable       csr_write_data (iteration count, 5b)
//
// One request enters per cycle while req_ready is high; each result passes through
// MAX_STEPS micro-rotation register stages and then a saturating output register.
// Every stage has its own ready, so a stalled response backs up the pipe stage
// by stage while empty stages keep accepting requests; nothing is lost or repeated.
// Synchronous reset empties the pipeline and sets the iteration count to 16.
// Stages beyond the configured count pass their vector through unchanged.

module cordic_sine_cosine #(
   parameter int MAX_STEPS = csc_pkg::DEFAULT_MAX_STEPS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic signed [csc_pkg::ANGLE_WIDTH-1:0]  req_angle,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [csc_pkg::OUT_WIDTH-1:0]    rsp_cosine,
   output logic signed [csc_pkg::OUT_WIDTH-1:0]    rsp_sine,
   input  logic                                    csr_write_enable,
   input  logic [csc_pkg::COUNT_WIDTH-1:0]         csr_write_data
);
   import csc_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] steps;
   rot_type                chain_data  [MAX_STEPS+1];
   logic                   chain_valid [MAX_STEPS+1];
   logic                   chain_ready [MAX_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= COUNT_WIDTH'(COUNT_RESET);
      end else if (csr_write_enable) begin
         count_ff <= csr_write_data;
      end
   end

   // A count above the pipeline length runs every stage.
   assign steps = (count_ff > COUNT_WIDTH'(MAX_STEPS)) ? COUNT_WIDTH'(MAX_STEPS) : count_ff;

   assign chain_valid[0]  = req_valid;
   assign req_ready       = chain_ready[0];
   assign chain_data[0].x = XY_WIDTH'(GAIN_Q16);
   assign chain_data[0].y = '0;
   assign chain_data[0].z = Z_WIDTH'(req_angle);

   for (genvar i = 0; i < MAX_STEPS; i++) begin : g_stage
      csc_stage #(
         .STAGE (i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .enable   (steps > COUNT_WIDTH'(i)),
         .up_valid (chain_valid[i]),
         .up_ready (chain_ready[i]),
         .up_data  (chain_data[i]),
         .dn_valid (chain_valid[i+1]),
         .dn_ready (chain_ready[i+1]),
         .dn_data  (chain_data[i+1])
      );
   end

   csc_output u_output (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (chain_valid[MAX_STEPS]),
      .up_ready   (chain_ready[MAX_STEPS]),
      .up_data    (chain_data[MAX_STEPS]),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_cosine (rsp_cosine),
      .rsp_sine   (rsp_sine)
   );

endmodule

### rtl/csc_stage.sv
`include "cordic_sine_cosine_macros.svh"

module csc_stage #(
   parameter int STAGE = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             up_valid,
   output logic             up_ready,
   input  csc_pkg::rot_type up_data,
   output logic             dn_valid,
   input  logic             dn_ready,
   output csc_pkg::rot_type dn_data
);
   import csc_pkg::*;

   localparam z_type ATAN = arctan_q15(STAGE);

   logic    valid_ff;
   rot_type data_ff;
   rot_type data_in;
   xy_type  x_shift;
   xy_type  y_shift;
   logic    load;

   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   // Arithmetic shifts round toward minus infinity, as the rotation requires.
   assign x_shift = $signed(up_data.x) >>> STAGE;
   assign y_shift = $signed(up_data.y) >>> STAGE;

   always_comb begin
      data_in = up_data;
      if (enable) begin
         if (!up_data.z[Z_WIDTH-1]) begin
            data_in.x = up_data.x - y_shift;
            data_in.y = up_data.y + x_shift;
            data_in.z = up_data.z - ATAN;
         end else begin
            data_in.x = up_data.x + y_shift;
            data_in.y = up_data.y - x_shift;
            data_in.z = up_data.z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

   `CSC_ASSERT_NEXT(a_stall_holds, clock, reset, valid_ff && !dn_ready,
                    valid_ff && $stable(data_ff))
   `CSC_ASSERT_NEXT(a_bypass_passes, clock, reset, load && !enable,
                    data_ff == $past(up_data))

endmodule

### rtl/csc_output.sv
`include "cordic_sine_cosine_macros.svh"

module csc_output (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_ready,
   input  csc_pkg::rot_type                      up_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [csc_pkg::OUT_WIDTH-1:0]  rsp_cosine,
   output logic signed [csc_pkg::OUT_WIDTH-1:0]  rsp_sine
);
   import csc_pkg::*;

   localparam xy_type XY_MAX = XY_WIDTH'(OUT_LIMIT);
   localparam xy_type XY_MIN = -XY_WIDTH'(OUT_LIMIT);
   localparam logic signed [OUT_WIDTH-1:0] OUT_MAX = OUT_WIDTH'(OUT_LIMIT);
   localparam logic signed [OUT_WIDTH-1:0] OUT_MIN = -OUT_WIDTH'(OUT_LIMIT);

   logic                        valid_ff;
   logic signed [OUT_WIDTH-1:0] cosine_ff;
   logic signed [OUT_WIDTH-1:0] sine_ff;
   logic signed [OUT_WIDTH-1:0] cosine_in;
   logic signed [OUT_WIDTH-1:0] sine_in;
   logic                        load;

   function automatic logic signed [OUT_WIDTH-1:0] clamp(input xy_type v);
      logic signed [OUT_WIDTH-1:0] r;
      priority if (v > XY_MAX) begin
         r = OUT_MAX;
      end else if (v < XY_MIN) begin
         r = OUT_MIN;
      end else begin
         r = v[OUT_WIDTH-1:0];
      end
      return r;
   endfunction

   assign up_ready   = !valid_ff || rsp_ready;
   assign load       = up_valid && up_ready;
   assign cosine_in  = clamp(up_data.x);
   assign sine_in    = clamp(up_data.y);
   assign rsp_valid  = valid_ff;
   assign rsp_cosine = cosine_ff;
   assign rsp_sine   = sine_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cosine_ff <= cosine_in;
         sine_ff   <= sine_in;
      end
   end

   `CSC_ASSERT_NOW(a_result_in_range, clock, reset, valid_ff,
                   cosine_ff <= OUT_MAX && cosine_ff >= OUT_MIN &&
                   sine_ff <= OUT_MAX && sine_ff >= OUT_MIN)

endmodule
